>>> src/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg: shared types, constants and code table
// Character codes, widths of the symbol pattern, the command word that
// travels from the front end to the back end, and the Morse table lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msd_pkg;

  localparam int MAX_SYMBOLS = 5;
  localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int KEY_W       = 6;
  localparam int TABLE_LEN   = 5;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = PTR_W + 1;

  localparam logic [7:0] CH_DOT     = 8'd46;
  localparam logic [7:0] CH_DASH    = 8'd45;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  localparam logic [7:0] REPL_RESET = 8'd63;

  // One queued command: a first result, optionally followed by a newline.
  typedef struct packed {
    logic [7:0] ch;
    logic       unk;
    logic       two;
  } msd_cmd_t;

  // Key is a leading one followed by the symbols, dash = 1.
  function automatic logic [7:0] code_lookup(logic [KEY_W-1:0] key);
    logic [7:0] ch;
    case (key)
      6'd2:    ch = "E";
      6'd3:    ch = "T";
      6'd4:    ch = "I";
      6'd5:    ch = "A";
      6'd6:    ch = "N";
      6'd7:    ch = "M";
      6'd8:    ch = "S";
      6'd9:    ch = "U";
      6'd10:   ch = "R";
      6'd11:   ch = "W";
      6'd12:   ch = "D";
      6'd13:   ch = "K";
      6'd14:   ch = "G";
      6'd15:   ch = "O";
      6'd16:   ch = "H";
      6'd17:   ch = "V";
      6'd18:   ch = "F";
      6'd20:   ch = "L";
      6'd22:   ch = "P";
      6'd23:   ch = "J";
      6'd24:   ch = "B";
      6'd25:   ch = "X";
      6'd26:   ch = "C";
      6'd27:   ch = "Y";
      6'd28:   ch = "Z";
      6'd29:   ch = "Q";
      6'd32:   ch = "5";
      6'd33:   ch = "4";
      6'd35:   ch = "3";
      6'd39:   ch = "2";
      6'd47:   ch = "1";
      6'd48:   ch = "6";
      6'd56:   ch = "7";
      6'd60:   ch = "8";
      6'd62:   ch = "9";
      6'd63:   ch = "0";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  // Build the table key from a symbol count and pattern; zero means no entry.
  function automatic logic [7:0] decode_letter(logic [CNT_W-1:0] count,
                                               logic [MAX_SYMBOLS-1:0] pattern);
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] lead;
    logic [7:0]       ch;
    ch   = 8'd0;
    lead = '0;
    key  = '0;
    if (count != '0 && int'(count) <= TABLE_LEN) begin
      lead = KEY_W'(1) << count;
      key  = lead | (KEY_W'(pattern) & (lead - KEY_W'(1)));
      ch   = code_lookup(key);
    end
    return ch;
  endfunction

endpackage

>>> src/morse_stream_decoder.sv
// ----------------------------------------------------------------------------
// morse_stream_decoder: Morse code text stream decoder
// Turns a stream of dot, dash, space and newline bytes into ASCII letters,
// digits, word spaces and newlines.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | push / full        | text_byte[7:0]
//  result   | pop / empty        | out_char[7:0], unknown_code, last_of_run
//  config   | cfg_write          | cfg_data[7:0] (replacement byte, reset '?')
//
// One item is accepted per cycle while full is low; the front end classifies it
// and updates the letter state at once, and its results are registered in the queue.
// A letter closed by a newline takes two pops. A four-entry command queue lets
// the input run while the result side stalls; full rises once four commands
// wait and drops the cycle after the head is taken. Reset (rst, synchronous)
// clears the letter state, empties the queue and sets the replacement to 63.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module morse_stream_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       unknown_code,
  output logic       last_of_run,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data
);

  logic              accept;
  logic              cmd_valid;
  msd_pkg::msd_cmd_t cmd;
  logic              head_valid;
  msd_pkg::msd_cmd_t head_cmd;
  logic              head_take;

  // advance the letter state on every accepted item
  assign accept = push && !full;

  msd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_byte (text_byte),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // queue only items that produce results; drop the rest here
  msd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (accept && cmd_valid),
    .wr_cmd     (cmd),
    .full       (full),
    .rd_en      (head_take),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  msd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .head_take    (head_take),
    .empty        (empty),
    .pop          (pop),
    .out_char     (out_char),
    .unknown_code (unknown_code),
    .last_of_run  (last_of_run)
  );

endmodule

>>> src/msd_front.sv
// ----------------------------------------------------------------------------
// msd_front: character classifier and letter builder
// Holds the symbol pattern and spacing state, and forms one command per
// accepted item that produces any result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        text_byte,
  input  logic              cfg_write,
  input  logic [7:0]        cfg_data,
  output logic              cmd_valid,
  output msd_pkg::msd_cmd_t cmd
);

  logic [7:0]                       repl;
  logic [msd_pkg::MAX_SYMBOLS-1:0]  pattern_bits;
  logic [msd_pkg::MAX_SYMBOLS-1:0]  pattern_bits_next;
  logic [msd_pkg::CNT_W-1:0]        symbol_count;
  logic [msd_pkg::CNT_W-1:0]        symbol_count_next;
  logic [1:0]                       space_run;
  logic [1:0]                       space_run_next;
  logic                             line_has_letter;
  logic                             line_has_letter_next;
  logic                             too_long;
  logic                             too_long_next;

  logic       is_sym;
  logic       is_space;
  logic       is_newline;
  logic [7:0] letter;
  logic       letter_bad;

  assign is_sym     = (text_byte == msd_pkg::CH_DOT) || (text_byte == msd_pkg::CH_DASH);
  assign is_space   = (text_byte == msd_pkg::CH_SPACE);
  assign is_newline = (text_byte == msd_pkg::CH_NEWLINE);

  assign letter     = msd_pkg::decode_letter(symbol_count, pattern_bits);
  assign letter_bad = too_long || (letter == 8'd0);

  always_comb begin
    pattern_bits_next    = pattern_bits;
    symbol_count_next    = symbol_count;
    space_run_next       = space_run;
    line_has_letter_next = line_has_letter;
    too_long_next        = too_long;
    cmd_valid            = 1'b0;
    cmd.ch               = letter_bad ? repl : letter;
    cmd.unk              = letter_bad;
    cmd.two              = 1'b0;

    if (is_sym) begin
      // word gap: emit a space before the first symbol of the next letter
      cmd_valid      = (space_run >= 2'd2) && line_has_letter && (symbol_count == '0);
      cmd.ch         = msd_pkg::CH_SPACE;
      cmd.unk        = 1'b0;
      space_run_next = 2'd0;
      if (int'(symbol_count) < msd_pkg::MAX_SYMBOLS) begin
        pattern_bits_next = {pattern_bits[msd_pkg::MAX_SYMBOLS-2:0],
                             (text_byte == msd_pkg::CH_DASH)};
        symbol_count_next = symbol_count + msd_pkg::CNT_W'(1);
      end else begin
        too_long_next = 1'b1;
      end
    end else if (is_space) begin
      if (symbol_count != '0) begin
        cmd_valid            = 1'b1;
        pattern_bits_next    = '0;
        symbol_count_next    = '0;
        too_long_next        = 1'b0;
        line_has_letter_next = 1'b1;
        space_run_next       = 2'd1;
      end else if (space_run != 2'd3) begin
        space_run_next = space_run + 2'd1;
      end
    end else if (is_newline) begin
      cmd_valid = 1'b1;
      if (symbol_count != '0) begin
        cmd.two = 1'b1;
      end else begin
        cmd.ch  = msd_pkg::CH_NEWLINE;
        cmd.unk = 1'b0;
      end
      pattern_bits_next    = '0;
      symbol_count_next    = '0;
      too_long_next        = 1'b0;
      space_run_next       = 2'd0;
      line_has_letter_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repl            <= msd_pkg::REPL_RESET;
      pattern_bits    <= '0;
      symbol_count    <= '0;
      space_run       <= 2'd0;
      line_has_letter <= 1'b0;
      too_long        <= 1'b0;
    end else begin
      if (cfg_write) begin
        repl <= cfg_data;
      end
      if (accept) begin
        pattern_bits    <= pattern_bits_next;
        symbol_count    <= symbol_count_next;
        space_run       <= space_run_next;
        line_has_letter <= line_has_letter_next;
        too_long        <= too_long_next;
      end
    end
  end

endmodule

>>> src/msd_queue.sv
// ----------------------------------------------------------------------------
// msd_queue: command queue between front and back end
// Small register FIFO; the head entry is read at the read pointer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  msd_pkg::msd_cmd_t wr_cmd,
  output logic              full,
  input  logic              rd_en,
  output logic              head_valid,
  output msd_pkg::msd_cmd_t head_cmd
);

  msd_pkg::msd_cmd_t           entries [msd_pkg::QUEUE_DEPTH];
  logic [msd_pkg::PTR_W-1:0]   wr_ptr;
  logic [msd_pkg::PTR_W-1:0]   rd_ptr;
  logic [msd_pkg::FILL_W-1:0]  fill;

  assign full       = (fill == msd_pkg::FILL_W'(msd_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + msd_pkg::PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + msd_pkg::PTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + msd_pkg::FILL_W'(1);
        2'b01:   fill <= fill - msd_pkg::FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> src/msd_back.sv
// ----------------------------------------------------------------------------
// msd_back: result sequencer
// Expands each queued command into one or two result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  msd_pkg::msd_cmd_t head_cmd,
  output logic              head_take,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_char,
  output logic              unknown_code,
  output logic              last_of_run
);

  logic second;
  logic done;

  assign empty        = !head_valid;
  assign out_char     = second ? msd_pkg::CH_NEWLINE : head_cmd.ch;
  assign unknown_code = !second && head_cmd.unk;
  assign last_of_run  = second || !head_cmd.two;
  assign done         = pop && head_valid;
  assign head_take    = done && last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (done) begin
      second <= !last_of_run;
    end
  end

endmodule
